[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent checks with an async active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/sds_pkg.sv]
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types and constants of the scanline descriptor sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sds_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_LINES = 2048;

	localparam int REG_W  = 11;
	localparam int IDX_W  = 3;
	localparam int ROW_W  = 10;
	localparam int CNT_W  = 10;
	localparam int OFS_W  = 20;
	localparam int FRM_W  = 32;

	// register indexes
	localparam logic [IDX_W-1:0] RI_VSYNC = 3'd0;
	localparam logic [IDX_W-1:0] RI_BACK  = 3'd1;
	localparam logic [IDX_W-1:0] RI_ACT   = 3'd2;
	localparam logic [IDX_W-1:0] RI_FRONT = 3'd3;
	localparam logic [IDX_W-1:0] RI_TOTAL = 3'd4;
	localparam logic [IDX_W-1:0] RI_WIDTH = 3'd5;

	typedef enum logic [2:0] {
		EK_VSYNC  = 3'd0,
		EK_DARK   = 3'd1,
		EK_PREFIX = 3'd2,
		EK_DATA   = 3'd3,
		EK_PORCH  = 3'd4,
		EK_END    = 3'd5
	} entry_kind_t;

	typedef enum logic [1:0] {
		LC_VSYNC = 2'd0,
		LC_DARK  = 2'd1,
		LC_IMAGE = 2'd2
	} line_class_t;

	typedef struct packed {
		logic [REG_W-1:0] vsync;
		logic [REG_W-1:0] back;
		logic [REG_W-1:0] act;
		logic [REG_W-1:0] front;
		logic [REG_W-1:0] total;
		logic [REG_W-1:0] width;
	} timing_cfg_t;

	typedef struct packed {
		line_class_t      cls;
		logic             blank;
		logic [ROW_W-1:0] row;
		logic [REG_W-1:0] wid;
	} line_info_t;

endpackage

`default_nettype wire

[hw/rtl/sds_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sds_cfg_regs
// Timing register file: write-only, reset to the 640x480 VGA timing.
// ----------------------------------------------------------------------------
`default_nettype none

module sds_cfg_regs import sds_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0] cfg_data,
	output timing_cfg_t           cfg
);

	timing_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vsync <= 11'd2;
			cfg_q.back  <= 11'd33;
			cfg_q.act   <= 11'd480;
			cfg_q.front <= 11'd10;
			cfg_q.total <= 11'd525;
			cfg_q.width <= 11'd320;
		end else if (cfg_we) begin
			case (cfg_index)
				RI_VSYNC: cfg_q.vsync <= cfg_data;
				RI_BACK:  cfg_q.back  <= cfg_data;
				RI_ACT:   cfg_q.act   <= cfg_data;
				RI_FRONT: cfg_q.front <= cfg_data;
				RI_TOTAL: cfg_q.total <= cfg_data;
				RI_WIDTH: cfg_q.width <= cfg_data;
				default:  ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/sds_line_class.sv]
// ----------------------------------------------------------------------------
// sds_line_class
// Classifies a scanline (sync / dark / image), blank flag, image row and saturated row width.
// ----------------------------------------------------------------------------
`default_nettype none

module sds_line_class import sds_pkg::*; (
	input  wire timing_cfg_t       cfg,
	input  wire logic [REG_W-1:0]  line,
	output line_info_t             info
);

	logic [REG_W:0] vsbp;
	logic [REG_W:0] line_x;
	logic [REG_W:0] diff;
	logic [REG_W:0] line_fp;
	logic           in_top;

	always_comb begin
		line_x  = {1'b0, line};
		vsbp    = {1'b0, cfg.vsync} + {1'b0, cfg.back};
		diff    = line_x - vsbp;
		line_fp = line_x + {1'b0, cfg.front};
		in_top  = line_x < vsbp;

		info.blank = in_top || (line_fp >= {1'b0, cfg.total});
		// diff only meaningful below the image start check; row from it
		info.row   = diff[REG_W-1:1];

		if (line < cfg.vsync)
			info.cls = LC_VSYNC;
		else if (in_top || diff >= {1'b0, cfg.act})
			info.cls = LC_DARK;
		else
			info.cls = LC_IMAGE;

		// saturate row width
		if ({2'b00, cfg.width} > 13'(MAX_WIDTH))
			info.wid = REG_W'(MAX_WIDTH);
		else
			info.wid = cfg.width;
	end

endmodule

`default_nettype wire

[hw/rtl/scanline_descriptor_sequencer.sv]
// ----------------------------------------------------------------------------
// scanline_descriptor_sequencer
// Vertical timing sequencer: one scanline tick in, descriptor words out.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready, scanline_done): one word per finished
//    scanline. A word with scanline_done low is taken and dropped.
//  - Output channel (out_valid/out_ready): descriptor words for the new line,
//    two for sync or dark lines (block + end mark), four for image lines
//    (prefix, data, front porch, end mark). last marks the end mark.
//  - Config port (cfg_we/cfg_index/cfg_data): write-only timing registers;
//    the user writes them only while the block is idle; the block does not enforce it.
// After a tick is taken the emitter goes busy (busy_s1, registered) and then
// loads the first descriptor word into the output register; one word per cycle
// follows while out_ready stays high. A tick's 2 or 4 words drain through the
// single output register, so a new tick is not taken while a line drains; the
// next tick is taken in the cycle its final word is loaded.
// Reset: line 0, frame 0, buffer index 0, timing registers at 640x480 VGA.
// A stalled receiver holds the output word; the line being drained holds and
// in_ready stays low until its end mark is loaded.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module scanline_descriptor_sequencer import sds_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// config
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0] cfg_data,
	// tick input
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             scanline_done,
	// descriptor output
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [2:0]            entry_kind,
	output logic [CNT_W-1:0]      word_count,
	output logic [OFS_W-1:0]      data_offset,
	output logic                  buffer_select,
	output logic [REG_W-1:0]      scan_line,
	output logic [FRM_W-1:0]      frame_count,
	output logic                  in_blank,
	output logic                  last
);

	timing_cfg_t cfg;
	line_info_t  info;

	// timing state, updated when a tick is taken; doubles as the line
	// register that the emitter reads while it drains
	logic [REG_W-1:0] line_q;
	logic [FRM_W-1:0] frame_q;
	logic             buf_q;

	// emitter
	logic             busy_s1;
	logic [1:0]       idx_s1;

	// output word register
	logic             out_valid_q;
	entry_kind_t      kind_q;
	logic [CNT_W-1:0] count_q;
	logic [OFS_W-1:0] offset_q;
	logic             bsel_q;
	logic [REG_W-1:0] line_out_q;
	logic [FRM_W-1:0] frame_out_q;
	logic             blank_q;
	logic             last_q;

	logic             in_fire;
	logic             tick;
	logic [REG_W:0]   nxt_line;
	logic             wrap;
	logic             out_load;
	logic             finishing;
	entry_kind_t      cur_kind;
	logic [CNT_W-1:0] cur_count;
	logic [OFS_W-1:0] cur_offset;
	logic             cur_last;
	logic [ROW_W+REG_W-1:0] product;

	sds_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sds_line_class u_class (
		.cfg  (cfg),
		.line (line_q),
		.info (info)
	);

	// --- tick intake ---
	assign in_fire = in_valid && in_ready;
	assign tick    = in_fire && scanline_done;

	always_comb begin
		nxt_line = {1'b0, line_q} + {{REG_W{1'b0}}, 1'b1};
		wrap     = (nxt_line >= {1'b0, cfg.total}) ||
		           ({1'b0, nxt_line} >= (REG_W+2)'(MAX_LINES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q  <= '0;
			frame_q <= '0;
			buf_q   <= 1'b0;
		end else if (tick) begin
			buf_q <= ~buf_q;
			if (wrap) begin
				line_q  <= '0;
				frame_q <= frame_q + 32'd1;
			end else begin
				line_q <= nxt_line[REG_W-1:0];
			end
		end
	end

	// --- entry selection for the line being drained ---
	assign product = info.row * info.wid;

	always_comb begin
		cur_kind   = EK_END;
		cur_count  = '0;
		cur_offset = '0;
		if (info.cls == LC_IMAGE) begin
			case (idx_s1)
				2'd0: begin
					cur_kind  = EK_PREFIX;
					cur_count = 10'd3;
				end
				2'd1: begin
					cur_kind   = EK_DATA;
					cur_count  = info.wid[REG_W-1:1];
					cur_offset = product[OFS_W-1:0];
				end
				2'd2: begin
					cur_kind  = EK_PORCH;
					cur_count = 10'd1;
				end
				default: ;
			endcase
		end else if (idx_s1 == 2'd0) begin
			cur_kind  = (info.cls == LC_VSYNC) ? EK_VSYNC : EK_DARK;
			cur_count = 10'd2;
		end
		cur_last = (cur_kind == EK_END);
	end

	assign out_load  = busy_s1 && (!out_valid_q || out_ready);
	assign finishing = out_load && cur_last;
	assign in_ready  = !busy_s1 || finishing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			idx_s1  <= '0;
		end else if (tick) begin
			busy_s1 <= 1'b1;
			idx_s1  <= '0;
		end else if (finishing) begin
			busy_s1 <= 1'b0;
		end else if (out_load) begin
			idx_s1 <= idx_s1 + 2'd1;
		end
	end

	// --- output register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q      <= cur_kind;
			count_q     <= cur_count;
			offset_q    <= cur_offset;
			bsel_q      <= ~buf_q;     // buffer index before the toggle
			line_out_q  <= line_q;
			frame_out_q <= frame_q;
			blank_q     <= info.blank;
			last_q      <= cur_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign entry_kind    = kind_q;
	assign word_count    = count_q;
	assign data_offset   = offset_q;
	assign buffer_select = bsel_q;
	assign scan_line     = line_out_q;
	assign frame_count   = frame_out_q;
	assign in_blank      = blank_q;
	assign last          = last_q;

	// --- checks ---
	`CHK_IMPL(a_no_overrun, clk, arst_n, in_ready && busy_s1, finishing,
		"tick taken while a line is still draining")
	`CHK_NEXT(a_tick_starts, clk, arst_n, tick, busy_s1 && idx_s1 == 2'd0,
		"tick did not restart the emitter")
	`CHK_IMPL(a_frame_on_wrap, clk, arst_n, !$stable(frame_q), line_q == '0,
		"frame counter moved without a line wrap")

endmodule

`default_nettype wire

[sim/tb_scanline_descriptor_sequencer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scanline_descriptor_sequencer
// Self-checking bench for the scanline descriptor sequencer. A driver feeds
// scanline ticks from a queue, a predictor works out each line's descriptor
// words, and a monitor compares every output word with the oldest prediction.
// Timing registers are rewritten between phases, from reset values through
// tiny frames, extremes and random setups, to one short complete frame.
// ----------------------------------------------------------------------------

module tb_scanline_descriptor_sequencer;
	import sds_pkg::*;

	// cycles with no handshake on either channel before the run is declared hung
	localparam int QUIET_LIMIT = 400;
	// settle time after the last word
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		entry_kind_t      kind;
		logic [CNT_W-1:0] words;
		logic [OFS_W-1:0] offset;
		logic             bsel;
		logic [REG_W-1:0] line;
		logic [FRM_W-1:0] frame;
		logic             blank;
		logic             last;
	} line_desc_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             scanline_done = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [2:0]       entry_kind;
	logic [CNT_W-1:0] word_count;
	logic [OFS_W-1:0] data_offset;
	logic             buffer_select;
	logic [REG_W-1:0] scan_line;
	logic [FRM_W-1:0] frame_count;
	logic             in_blank;
	logic             last;

	// pending ticks and predicted descriptor words
	bit         tick_q[$];
	line_desc_t line_desc_q[$];

	// predictor copy of the timing registers (reset values) and line state
	logic [REG_W-1:0] vt_reg [6] = '{11'd2, 11'd33, 11'd480, 11'd10, 11'd525, 11'd320};
	logic [REG_W-1:0] cur_line = '0;
	logic [FRM_W-1:0] frame_ctr = '0;
	logic             buf_idx = 1'b0;

	// idle chance in percent per free slot, set per phase
	int send_pct = 0;
	int recv_pct = 0;
	int send_gap = 0;
	int recv_stall = 0;
	int quiet = 0;
	int mismatches = 0;

	always #10 clk = ~clk;

	scanline_descriptor_sequencer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.scanline_done(scanline_done),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.entry_kind   (entry_kind),
		.word_count   (word_count),
		.data_offset  (data_offset),
		.buffer_select(buffer_select),
		.scan_line    (scan_line),
		.frame_count  (frame_count),
		.in_blank     (in_blank),
		.last         (last)
	);

	// Advance the line counter for one tick and queue the new line's words.
	// A tick with scanline_done low changes nothing.
	function automatic void advance_scanline(logic done);
		int vs = vt_reg[RI_VSYNC];
		int bp = vt_reg[RI_BACK];
		int act = vt_reg[RI_ACT];
		int fp = vt_reg[RI_FRONT];
		int tot = vt_reg[RI_TOTAL];
		int wid = vt_reg[RI_WIDTH];
		int ln;
		line_desc_t d;
		if (!done)
			return;
		d.bsel = buf_idx;
		buf_idx = ~buf_idx;
		// wrap at total, also when the counter already sits past it
		ln = int'(cur_line) + 1;
		if (ln >= tot || ln >= MAX_LINES) begin
			frame_ctr = frame_ctr + 1;
			ln = 0;
		end
		cur_line = ln[REG_W-1:0];
		if (wid > MAX_WIDTH)
			wid = MAX_WIDTH;
		d.line = cur_line;
		d.frame = frame_ctr;
		d.blank = (ln < vs + bp) || (ln + fp >= tot);
		d.last = 1'b0;
		d.offset = '0;
		if (ln < vs) begin
			d.kind = EK_VSYNC;
			d.words = 10'd2;
			line_desc_q.push_back(d);
		end else if (ln < vs + bp || ln - vs - bp >= act) begin
			d.kind = EK_DARK;
			d.words = 10'd2;
			line_desc_q.push_back(d);
		end else begin
			d.kind = EK_PREFIX;
			d.words = 10'd3;
			line_desc_q.push_back(d);
			// rows are doubled: two scanlines per frame-buffer row
			d.kind = EK_DATA;
			d.words = CNT_W'(wid >> 1);
			d.offset = OFS_W'(((ln - vs - bp) >> 1) * wid);
			line_desc_q.push_back(d);
			d.kind = EK_PORCH;
			d.words = 10'd1;
			d.offset = '0;
			line_desc_q.push_back(d);
		end
		d.kind = EK_END;
		d.words = '0;
		d.last = 1'b1;
		line_desc_q.push_back(d);
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("%0t ns: %s", $time, msg);
	endtask

	// Tick driver: valid holds with its payload until taken; random gaps open
	// between words when send_pct allows.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			scanline_done <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				advance_scanline(scanline_done);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (send_pct > 0 && $urandom_range(99) < send_pct) begin
					send_gap <= $urandom_range(7);
					in_valid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					in_valid <= 1'b1;
					scanline_done <= tick_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Descriptor monitor: stalls in random bursts, independent of out_valid,
	// so stalls land on every word position of a line.
	always @(posedge clk or negedge arst_n) begin : desc_mon
		line_desc_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (line_desc_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word kind %0d line %0d",
						entry_kind, scan_line));
				end else begin
					e = line_desc_q.pop_front();
					if (entry_kind !== e.kind)
						report_mismatch($sformatf("line %0d entry_kind %0d, want %s",
							e.line, entry_kind, e.kind.name()));
					if (word_count !== e.words)
						report_mismatch($sformatf("line %0d %s word_count %0d, want %0d",
							e.line, e.kind.name(), word_count, e.words));
					if (data_offset !== e.offset)
						report_mismatch($sformatf("line %0d %s data_offset %0d, want %0d",
							e.line, e.kind.name(), data_offset, e.offset));
					if (buffer_select !== e.bsel)
						report_mismatch($sformatf("line %0d %s buffer_select %b, want %b",
							e.line, e.kind.name(), buffer_select, e.bsel));
					if (scan_line !== e.line)
						report_mismatch($sformatf("%s scan_line %0d, want %0d",
							e.kind.name(), scan_line, e.line));
					if (frame_count !== e.frame)
						report_mismatch($sformatf("line %0d %s frame_count %0d, want %0d",
							e.line, e.kind.name(), frame_count, e.frame));
					if (in_blank !== e.blank)
						report_mismatch($sformatf("line %0d %s in_blank %b, want %b",
							e.line, e.kind.name(), in_blank, e.blank));
					if (last !== e.last)
						report_mismatch($sformatf("line %0d %s last %b, want %b",
							e.line, e.kind.name(), last, e.last));
				end
			end
			if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				out_ready <= 1'b0;
			end else if (recv_pct > 0 && $urandom_range(99) < recv_pct) begin
				recv_stall <= $urandom_range(7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: a run with no handshake for too long is hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// One register write; indexes past the last register only reach the RTL.
	task automatic write_timing(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx <= RI_WIDTH)
			vt_reg[idx] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_timing(int vs, int bp, int act, int fp, int tot, int wid);
		write_timing(RI_VSYNC, REG_W'(vs));
		write_timing(RI_BACK, REG_W'(bp));
		write_timing(RI_ACT, REG_W'(act));
		write_timing(RI_FRONT, REG_W'(fp));
		write_timing(RI_TOTAL, REG_W'(tot));
		write_timing(RI_WIDTH, REG_W'(wid));
	endtask

	task automatic queue_ticks(int n);
		repeat (n)
			tick_q.push_back(1'b1);
	endtask

	// Wait until every tick is taken and every predicted word has come out,
	// then leave room for a dropped tick still in flight.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (tick_q.size() != 0 || in_valid || line_desc_q.size() != 0);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	initial begin : stim
		int n;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;

		// Reset timing: sync line, a dropped tick, then back porch lines.
		tick_q.push_back(1'b1);
		tick_q.push_back(1'b0);
		queue_ticks(2);
		wait_drained();

		// Tiny frame with an odd wide row: every line class, wrap and frame
		// count. Writes to the unused indexes must leave the registers alone.
		set_timing(1, 1, 4, 1, 8, 1023);
		write_timing(IDX_W'(RI_WIDTH + 1), '1);
		write_timing(IDX_W'(RI_WIDTH + 2), '0);
		queue_ticks(10);
		wait_drained();

		// No sync, no back porch, front porch above total, width saturates.
		set_timing(0, 0, 2047, 2047, 3, 2047);
		queue_ticks(5);
		wait_drained();

		// Total of zero wraps on every tick; a huge sync region covers it all.
		set_timing(2047, 2047, 0, 0, 0, 0);
		queue_ticks(3);
		wait_drained();

		// Random setups, small frames so that wraps and image lines are common.
		send_pct = 25;
		recv_pct = 25;
		for (int ph = 0; ph < 5; ph++) begin
			send_pct = (ph == 1) ? 0 : 25;
			recv_pct = (ph == 2) ? 0 : 25;
			set_timing($urandom_range(0, 3), $urandom_range(0, 4), $urandom_range(0, 12),
				$urandom_range(0, 5), $urandom_range(1, 24),
				($urandom_range(3) == 0) ? $urandom_range(1025, 2047)
				: $urandom_range(0, 64));
			n = 0;
			while (n < 10) begin
				if ($urandom_range(9) == 0) begin
					tick_q.push_back(1'b0);
				end else begin
					tick_q.push_back(1'b1);
					n++;
					// hold off the sender once until all words are out
					if (ph == 3 && n == 5)
						wait_drained();
				end
			end
			wait_drained();
		end

		// One complete short frame, no idling: image rows at the widest row,
		// dark lines after the image and the wrap back to line zero.
		send_pct = 0;
		recv_pct = 0;
		set_timing(0, 2, 20, 5, 24, 1024);
		queue_ticks(26);
		wait_drained();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
